FILE: rtl/x64_mov_sib_access_decoder_defines.svh
// ----------------------------------------------------------------------------
// x64 mov SIB access decoder: assertion macros
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef X64_MOV_SIB_ACCESS_DECODER_DEFINES_SVH
`define X64_MOV_SIB_ACCESS_DECODER_DEFINES_SVH

// same-cycle implication
`define XMSAD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define XMSAD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/xmsad_pkg.sv
// ----------------------------------------------------------------------------
// xmsad_pkg
// Types, constants and helpers shared by the mov SIB access decoder.
// ----------------------------------------------------------------------------
package xmsad_pkg;

    localparam int unsigned INSN_BYTES = 6;
    localparam int unsigned INSN_W     = 8 * INSN_BYTES;

    localparam logic [7:0] PFX_OPSIZE = 8'h66;
    localparam logic [7:0] REX_MASK   = 8'hF0;
    localparam logic [7:0] REX_BASE   = 8'h40;
    localparam logic [7:0] OP_MOV_ST8 = 8'h88;
    localparam logic [7:0] OP_MOV_ST  = 8'h89;
    localparam logic [7:0] OP_MOV_LD  = 8'h8B;
    localparam logic [7:0] OP_ESC     = 8'h0F;
    localparam logic [7:0] OP_MOVZX8  = 8'hB6;
    localparam logic [7:0] OP_MOVZX16 = 8'hB7;

    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP32 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;
    localparam logic [2:0] RM_SIB     = 3'd4;
    localparam logic [2:0] SIB_NOIDX  = 3'd4;
    localparam logic [2:0] SIB_NOBASE = 3'b101;

    localparam logic [3:0] REG_RAX = 4'd0;
    localparam logic [3:0] REG_RCX = 4'd1;
    localparam logic [3:0] REG_RDX = 4'd2;
    localparam logic [3:0] REG_R14 = 4'd14;

    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    localparam logic MODE_FASTMEM   = 1'b0;
    localparam logic MODE_PAGETABLE = 1'b1;

    typedef struct packed {
        logic       accepted;
        logic       store;
        logic [1:0] size_code;
        logic [3:0] data_register;
        logic [3:0] address_register;
        logic [3:0] instruction_length;
    } t_result;

    function automatic logic [7:0] byte_at(input logic [INSN_W-1:0] bytes,
                                           input logic [2:0] pos);
        logic [7:0] b;
        case (pos)
            3'd0:    b = bytes[7:0];
            3'd1:    b = bytes[15:8];
            3'd2:    b = bytes[23:16];
            3'd3:    b = bytes[31:24];
            3'd4:    b = bytes[39:32];
            3'd5:    b = bytes[47:40];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/xmsad_decode.sv
// ----------------------------------------------------------------------------
// xmsad_decode
// Single-pass decode of prefixes, opcode, ModRM and SIB into one result.
// ----------------------------------------------------------------------------
module xmsad_decode (
    input  logic [xmsad_pkg::INSN_W-1:0] i_bytes,
    input  logic                         i_address_mode,
    output xmsad_pkg::t_result           o_result
);

    logic       opsize;
    logic [7:0] b_after_pfx;
    logic       rex;
    logic       rw, rr, rx, rb;
    logic [2:0] op_pos;
    logic [7:0] op;
    logic [7:0] op2;
    logic       esc;
    logic [2:0] modrm_pos;
    logic [2:0] sib_pos;
    logic [7:0] modrm;
    logic [7:0] sib;
    logic [1:0] mod;
    logic [3:0] data_reg;
    logic [3:0] index;
    logic [3:0] base;
    logic       write;
    logic [1:0] size;
    logic       op_ok;
    logic       addr_ok;
    logic       reg_ok;
    logic [3:0] addr_reg;
    logic [3:0] disp_len;
    logic [3:0] len;

    always_comb begin
        opsize      = (i_bytes[7:0] == xmsad_pkg::PFX_OPSIZE);
        b_after_pfx = opsize ? i_bytes[15:8] : i_bytes[7:0];
        rex         = ((b_after_pfx & xmsad_pkg::REX_MASK) == xmsad_pkg::REX_BASE);
        rw          = rex & b_after_pfx[3];
        rr          = rex & b_after_pfx[2];
        rx          = rex & b_after_pfx[1];
        rb          = rex & b_after_pfx[0];
        op_pos      = {2'b00, opsize} + {2'b00, rex};
        op          = xmsad_pkg::byte_at(i_bytes, op_pos);
        op2         = xmsad_pkg::byte_at(i_bytes, op_pos + 3'd1);
        esc         = (op == xmsad_pkg::OP_ESC);

        write = 1'b0;
        size  = xmsad_pkg::SIZE_8;
        op_ok = 1'b1;
        case (op)
            xmsad_pkg::OP_MOV_ST8: begin
                write = 1'b1;
                size  = xmsad_pkg::SIZE_8;
            end
            xmsad_pkg::OP_MOV_ST: begin
                write = 1'b1;
                size  = opsize ? xmsad_pkg::SIZE_16 :
                        (rw ? xmsad_pkg::SIZE_64 : xmsad_pkg::SIZE_32);
            end
            xmsad_pkg::OP_MOV_LD: begin
                op_ok = !opsize;
                size  = rw ? xmsad_pkg::SIZE_64 : xmsad_pkg::SIZE_32;
            end
            xmsad_pkg::OP_ESC: begin
                if (op2 == xmsad_pkg::OP_MOVZX8) begin
                    size = xmsad_pkg::SIZE_8;
                end else if (op2 == xmsad_pkg::OP_MOVZX16) begin
                    size = xmsad_pkg::SIZE_16;
                end else begin
                    op_ok = 1'b0;
                end
            end
            default: op_ok = 1'b0;
        endcase

        modrm_pos = op_pos + {2'b00, esc} + 3'd1;
        sib_pos   = modrm_pos + 3'd1;
        modrm     = xmsad_pkg::byte_at(i_bytes, modrm_pos);
        sib       = xmsad_pkg::byte_at(i_bytes, sib_pos);
        mod       = modrm[7:6];
        data_reg  = {rr, modrm[5:3]};
        index     = {rx, sib[5:3]};
        base      = {rb, sib[2:0]};

        addr_ok = (modrm[2:0] == xmsad_pkg::RM_SIB) && (mod != xmsad_pkg::MOD_REG)
               && (sib[7:6] == 2'd0)
               && !((mod == xmsad_pkg::MOD_NODISP) && (sib[2:0] == xmsad_pkg::SIB_NOBASE))
               && !(!rx && (sib[5:3] == xmsad_pkg::SIB_NOIDX));

        addr_reg = xmsad_pkg::REG_RCX;
        reg_ok   = 1'b1;
        if (i_address_mode == xmsad_pkg::MODE_FASTMEM) begin
            if (base == xmsad_pkg::REG_R14) begin
                addr_reg = index;
            end else if (index == xmsad_pkg::REG_R14) begin
                addr_reg = base;
            end else begin
                reg_ok = 1'b0;
            end
        end else begin
            reg_ok = (data_reg == (write ? xmsad_pkg::REG_RDX : xmsad_pkg::REG_RAX))
                  && ((index == xmsad_pkg::REG_RAX) || (base == xmsad_pkg::REG_RAX));
        end

        case (mod)
            xmsad_pkg::MOD_DISP8:  disp_len = 4'd1;
            xmsad_pkg::MOD_DISP32: disp_len = 4'd4;
            default:               disp_len = 4'd0;
        endcase
        len = {1'b0, sib_pos} + 4'd1 + disp_len;

        o_result = '0;
        if (op_ok && addr_ok && reg_ok) begin
            o_result.accepted           = 1'b1;
            o_result.store              = write;
            o_result.size_code          = size;
            o_result.data_register      = data_reg;
            o_result.address_register   = addr_reg;
            o_result.instruction_length = len;
        end
    end

endmodule

FILE: rtl/x64_mov_sib_access_decoder.sv
// An item is held in the input register, then its decode in the result register.
// Throughput: 1 item per cycle when the output is not stalled; the decode is
// one combinational pass between the input register and the result register.
// Reset: synchronous active-low i_rst_n clears both valid flags and sets
// address_mode to the fast memory form (0).
// ----------------------------------------------------------------------------
// x64_mov_sib_access_decoder
// Decodes mov/movzx SIB memory forms into direction, size, registers, length.
// ----------------------------------------------------------------------------
`include "x64_mov_sib_access_decoder_defines.svh"

module x64_mov_sib_access_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [xmsad_pkg::INSN_W-1:0] i_instruction_bytes,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_accepted,
    output logic                         o_store,
    output logic [1:0]                   o_size_code,
    output logic [3:0]                   o_data_register,
    output logic [3:0]                   o_address_register,
    output logic [3:0]                   o_instruction_length
);

    logic                         r_address_mode, n_address_mode;
    logic                         r_s1_valid, n_s1_valid;
    logic [xmsad_pkg::INSN_W-1:0] r_s1_bytes, n_s1_bytes;
    logic                         r_out_valid, n_out_valid;
    xmsad_pkg::t_result           r_result, n_result;
    xmsad_pkg::t_result           dec_result;
    logic                         s2_free;

    xmsad_decode u_decode (
        .i_bytes        (r_s1_bytes),
        .i_address_mode (r_address_mode),
        .o_result       (dec_result)
    );

    assign o_cfg_ready = 1'b1;
    assign s2_free     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_s1_valid && !s2_free;

    always_comb begin
        n_address_mode = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_address_mode;
        n_s1_valid     = o_in_stall ? r_s1_valid : i_in_valid;
        n_s1_bytes     = (i_in_valid && !o_in_stall) ? i_instruction_bytes : r_s1_bytes;
        n_out_valid    = s2_free ? r_s1_valid : r_out_valid;
        n_result       = s2_free ? dec_result : r_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address_mode <= xmsad_pkg::MODE_FASTMEM;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_address_mode <= n_address_mode;
            r_s1_valid     <= n_s1_valid;
            r_out_valid    <= n_out_valid;
        end
        r_s1_bytes <= n_s1_bytes;
        r_result   <= n_result;
    end

    assign o_out_valid          = r_out_valid;
    assign o_accepted           = r_result.accepted;
    assign o_store              = r_result.store;
    assign o_size_code          = r_result.size_code;
    assign o_data_register      = r_result.data_register;
    assign o_address_register   = r_result.address_register;
    assign o_instruction_length = r_result.instruction_length;

    `XMSAD_ASSERT_NOW(a_reject_zero, r_out_valid && !r_result.accepted,
        r_result == '0, "rejected item carries nonzero fields")
    `XMSAD_ASSERT_NOW(a_len_range, r_out_valid && r_result.accepted,
        (r_result.instruction_length >= 4'd3) && (r_result.instruction_length <= 4'd10),
        "accepted length out of range")
    `XMSAD_ASSERT_NEXT(a_s1_advance, r_s1_valid && s2_free, r_out_valid,
        "decoded item lost between stages")

endmodule

FILE: dv/tb_x64_mov_sib_access_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_x64_mov_sib_access_decoder
// Drives mov/movzx SIB instruction bytes through the decoder under random
// input gaps and output stalls, decodes each accepted item in the testbench
// for both address modes, and compares every result field in order.
// ----------------------------------------------------------------------------
class access_scoreboard;
    xmsad_pkg::t_result pending_q[$];
    logic               mode;
    int                 errors;

    function new();
        mode   = xmsad_pkg::MODE_FASTMEM;
        errors = 0;
    endfunction

    function logic [7:0] insn_byte(input logic [xmsad_pkg::INSN_W-1:0] insn,
                                   input logic [3:0] pos);
        if (pos >= xmsad_pkg::INSN_BYTES)
            return 8'h00;
        return insn[8*pos +: 8];
    endfunction

    function xmsad_pkg::t_result decode_access(input logic [xmsad_pkg::INSN_W-1:0] insn);
        xmsad_pkg::t_result r;
        logic [7:0]         b, modrm, sib;
        logic [3:0]         pos, vreg, idx, bas, areg;
        logic [1:0]         sz;
        logic               opsize, rw, rr, rx, rb, wr;
        r      = '0;
        pos    = 4'd0;
        opsize = 1'b0;
        rw     = 1'b0;
        rr     = 1'b0;
        rx     = 1'b0;
        rb     = 1'b0;
        b      = insn_byte(insn, pos);
        if (b == xmsad_pkg::PFX_OPSIZE) begin
            opsize = 1'b1;
            pos++;
            b = insn_byte(insn, pos);
        end
        if ((b & xmsad_pkg::REX_MASK) == xmsad_pkg::REX_BASE) begin
            {rw, rr, rx, rb} = b[3:0];
            pos++;
            b = insn_byte(insn, pos);
        end
        if (b == xmsad_pkg::OP_MOV_ST8) begin
            wr = 1'b1;
            sz = xmsad_pkg::SIZE_8;
        end else if (b == xmsad_pkg::OP_MOV_ST) begin
            wr = 1'b1;
            sz = opsize ? xmsad_pkg::SIZE_16 :
                 (rw ? xmsad_pkg::SIZE_64 : xmsad_pkg::SIZE_32);
        end else if (b == xmsad_pkg::OP_MOV_LD) begin
            if (opsize)
                return r;
            wr = 1'b0;
            sz = rw ? xmsad_pkg::SIZE_64 : xmsad_pkg::SIZE_32;
        end else if (b == xmsad_pkg::OP_ESC) begin
            pos++;
            b = insn_byte(insn, pos);
            if (b == xmsad_pkg::OP_MOVZX8)
                sz = xmsad_pkg::SIZE_8;
            else if (b == xmsad_pkg::OP_MOVZX16)
                sz = xmsad_pkg::SIZE_16;
            else
                return r;
            wr = 1'b0;
        end else begin
            return r;
        end
        pos++;
        modrm = insn_byte(insn, pos);
        pos++;
        if (modrm[2:0] != xmsad_pkg::RM_SIB || modrm[7:6] == xmsad_pkg::MOD_REG)
            return r;
        vreg = {rr, modrm[5:3]};
        sib  = insn_byte(insn, pos);
        pos++;
        if (sib[7:6] != 2'd0)
            return r;
        if (modrm[7:6] == xmsad_pkg::MOD_NODISP && sib[2:0] == xmsad_pkg::SIB_NOBASE)
            return r;
        if (!rx && sib[5:3] == xmsad_pkg::SIB_NOIDX)
            return r;
        idx = {rx, sib[5:3]};
        bas = {rb, sib[2:0]};
        if (mode == xmsad_pkg::MODE_FASTMEM) begin
            if (bas == xmsad_pkg::REG_R14)
                areg = idx;
            else if (idx == xmsad_pkg::REG_R14)
                areg = bas;
            else
                return r;
        end else begin
            if (vreg != (wr ? xmsad_pkg::REG_RDX : xmsad_pkg::REG_RAX))
                return r;
            if (idx != xmsad_pkg::REG_RAX && bas != xmsad_pkg::REG_RAX)
                return r;
            areg = xmsad_pkg::REG_RCX;
        end
        if (modrm[7:6] == xmsad_pkg::MOD_DISP8)
            pos += 4'd1;
        else if (modrm[7:6] == xmsad_pkg::MOD_DISP32)
            pos += 4'd4;
        r.accepted           = 1'b1;
        r.store              = wr;
        r.size_code          = sz;
        r.data_register      = vreg;
        r.address_register   = areg;
        r.instruction_length = pos;
        return r;
    endfunction

    function void note_item(input logic [xmsad_pkg::INSN_W-1:0] insn);
        pending_q.push_back(decode_access(insn));
    endfunction

    function void compare_field(input string fname, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, fname, want, got);
            errors++;
        end
    endfunction

    function void check_result(input xmsad_pkg::t_result got);
        xmsad_pkg::t_result want;
        if (pending_q.size() == 0) begin
            $display("%0t: result with no item pending, expected none got %h", $time, got);
            errors++;
            return;
        end
        want = pending_q.pop_front();
        compare_field("accepted", want.accepted, got.accepted);
        compare_field("store", want.store, got.store);
        compare_field("size_code", want.size_code, got.size_code);
        compare_field("data_register", want.data_register, got.data_register);
        compare_field("address_register", want.address_register, got.address_register);
        compare_field("instruction_length", want.instruction_length,
                      got.instruction_length);
    endfunction
endclass

module tb_x64_mov_sib_access_decoder;

    localparam int CYCLE_LIMIT = 200000;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic                         i_cfg_data;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [xmsad_pkg::INSN_W-1:0] i_instruction_bytes;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic                         o_accepted;
    logic                         o_store;
    logic [1:0]                   o_size_code;
    logic [3:0]                   o_data_register;
    logic [3:0]                   o_address_register;
    logic [3:0]                   o_instruction_length;

    xmsad_pkg::t_result           dut_result;
    access_scoreboard             sb;
    logic                         rx_hold = 1'b0;
    logic                         no_gaps = 1'b0;
    int                           items_taken = 0;
    int                           cycle_count = 0;

    x64_mov_sib_access_decoder dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_data           (i_cfg_data),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_instruction_bytes  (i_instruction_bytes),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_accepted           (o_accepted),
        .o_store              (o_store),
        .o_size_code          (o_size_code),
        .o_data_register      (o_data_register),
        .o_address_register   (o_address_register),
        .o_instruction_length (o_instruction_length)
    );

    assign dut_result = {o_accepted, o_store, o_size_code, o_data_register,
                         o_address_register, o_instruction_length};

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(dut_result);
        i_out_stall <= rx_hold || (!no_gaps && ($urandom_range(99) < 9));
    end

    // long output hold-off while the sender keeps going
    initial begin
        wait (items_taken >= 200);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (120) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    function automatic logic [xmsad_pkg::INSN_W-1:0] insn6(
        input logic [7:0] b0, b1, b2, b3, b4, b5);
        return {b5, b4, b3, b2, b1, b0};
    endfunction

    // well-formed SIB access with random content, biased toward the given mode
    function automatic logic [xmsad_pkg::INSN_W-1:0] gen_access(input logic mode);
        logic [7:0]                   b [xmsad_pkg::INSN_BYTES];
        logic [xmsad_pkg::INSN_W-1:0] w;
        logic [3:0]                   vreg, idx, bas;
        logic [1:0]                   md;
        logic                         pfx, has_rex, rw, wr;
        int                           op, p;
        for (int k = 0; k < xmsad_pkg::INSN_BYTES; k++)
            b[k] = 8'($urandom);
        op  = $urandom_range(4);
        wr  = (op < 2);
        pfx = ($urandom_range(3) == 0);
        if (op == 2 && $urandom_range(3) != 0)
            pfx = 1'b0;
        md = 2'($urandom_range(2));
        rw = 1'($urandom_range(1));
        if (mode == xmsad_pkg::MODE_FASTMEM) begin
            vreg = 4'($urandom);
            if ($urandom_range(1)) begin
                bas = xmsad_pkg::REG_R14;
                idx = 4'($urandom);
            end else begin
                idx = xmsad_pkg::REG_R14;
                bas = 4'($urandom);
            end
        end else begin
            vreg = wr ? xmsad_pkg::REG_RDX : xmsad_pkg::REG_RAX;
            if ($urandom_range(9) == 0)
                vreg = 4'($urandom);
            if ($urandom_range(1)) begin
                bas = xmsad_pkg::REG_RAX;
                idx = 4'($urandom);
            end else begin
                idx = xmsad_pkg::REG_RAX;
                bas = 4'($urandom);
            end
        end
        has_rex = $urandom_range(1) || rw || vreg[3] || idx[3] || bas[3];
        p = 0;
        if (pfx) begin
            b[p] = xmsad_pkg::PFX_OPSIZE;
            p++;
        end
        if (has_rex) begin
            b[p] = xmsad_pkg::REX_BASE | {4'h0, rw, vreg[3], idx[3], bas[3]};
            p++;
        end
        case (op)
            0: b[p] = xmsad_pkg::OP_MOV_ST8;
            1: b[p] = xmsad_pkg::OP_MOV_ST;
            2: b[p] = xmsad_pkg::OP_MOV_LD;
            default: begin
                b[p] = xmsad_pkg::OP_ESC;
                p++;
                b[p] = (op == 3) ? xmsad_pkg::OP_MOVZX8 : xmsad_pkg::OP_MOVZX16;
            end
        endcase
        p++;
        b[p] = {md, vreg[2:0], xmsad_pkg::RM_SIB};
        p++;
        b[p] = {2'b00, idx[2:0], bas[2:0]};
        for (int k = 0; k < xmsad_pkg::INSN_BYTES; k++)
            w[8*k +: 8] = b[k];
        return w;
    endfunction

    task automatic send_item(input logic [xmsad_pkg::INSN_W-1:0] insn);
        while (!no_gaps && $urandom_range(99) < 9) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_instruction_bytes <= insn;
        do
            @(posedge i_clk);
        while (o_in_stall);
        sb.note_item(insn);
        items_taken++;
    endtask

    task automatic set_address_mode(input logic m);
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.mode = m;
    endtask

    task automatic run_random(input int n);
        int                           pick;
        logic [xmsad_pkg::INSN_W-1:0] insn;
        for (int i = 0; i < n; i++) begin
            no_gaps <= (i >= n / 3 && i < n / 2);
            pick = $urandom_range(99);
            if (pick < 80)
                insn = gen_access(sb.mode);
            else if (pick < 90)
                insn = gen_access(sb.mode) ^ (48'h1 << $urandom_range(xmsad_pkg::INSN_W - 1));
            else
                insn = {16'($urandom), 32'($urandom)};
            send_item(insn);
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_valid         = 1'b0;
        i_cfg_data          = 1'b0;
        i_in_valid          = 1'b0;
        i_instruction_bytes = '0;
        sb                  = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fast memory form, reset mode
        send_item('0);
        send_item('1);
        send_item(insn6(xmsad_pkg::REX_BASE | 8'h0F, xmsad_pkg::OP_MOV_ST8,
                        8'h44, 8'h26, 8'h7F, 8'h00));
        send_item(insn6(xmsad_pkg::PFX_OPSIZE, xmsad_pkg::REX_BASE | 8'h01,
                        xmsad_pkg::OP_MOV_ST, 8'h84, 8'h06, 8'hAA));
        send_item(insn6(xmsad_pkg::PFX_OPSIZE, xmsad_pkg::REX_BASE | 8'h0B,
                        xmsad_pkg::OP_ESC, xmsad_pkg::OP_MOVZX16, 8'h94, 8'h36));
        send_item(insn6(xmsad_pkg::OP_ESC, xmsad_pkg::OP_MOVZX8,
                        8'h0C, 8'h06, 8'h00, 8'h00));
        send_item(insn6(xmsad_pkg::REX_BASE | 8'h01, xmsad_pkg::OP_ESC,
                        xmsad_pkg::OP_MOVZX8, 8'h0C, 8'h06, 8'h00));
        send_item(insn6(xmsad_pkg::PFX_OPSIZE, xmsad_pkg::REX_BASE | 8'h01,
                        xmsad_pkg::OP_MOV_LD, 8'h04, 8'h06, 8'h00));
        send_item(insn6(xmsad_pkg::REX_BASE | 8'h09, xmsad_pkg::OP_MOV_LD,
                        8'h4C, 8'h06, 8'h10, 8'h00));
        send_item(insn6(xmsad_pkg::OP_ESC, 8'hB8, 8'h04, 8'h06, 8'h00, 8'h00));
        send_item(insn6(xmsad_pkg::REX_BASE | 8'h01, xmsad_pkg::PFX_OPSIZE,
                        xmsad_pkg::OP_MOV_ST, 8'h04, 8'h06, 8'h00));
        send_item(insn6(xmsad_pkg::PFX_OPSIZE, xmsad_pkg::PFX_OPSIZE,
                        xmsad_pkg::OP_MOV_ST, 8'h04, 8'h06, 8'h00));
        send_item(insn6(xmsad_pkg::REX_BASE | 8'h03, xmsad_pkg::OP_MOV_ST,
                        8'h04, 8'h35, 8'h00, 8'h00));
        send_item(insn6(xmsad_pkg::REX_BASE | 8'h03, xmsad_pkg::OP_MOV_ST,
                        8'h44, 8'h35, 8'h08, 8'h00));
        send_item(insn6(xmsad_pkg::REX_BASE | 8'h01, xmsad_pkg::OP_MOV_ST,
                        8'h04, 8'h26, 8'h00, 8'h00));
        send_item(insn6(xmsad_pkg::REX_BASE | 8'h01, xmsad_pkg::OP_MOV_ST,
                        8'hC4, 8'h06, 8'h00, 8'h00));
        send_item(insn6(xmsad_pkg::REX_BASE | 8'h01, xmsad_pkg::OP_MOV_ST,
                        8'h05, 8'h06, 8'h00, 8'h00));
        send_item(insn6(xmsad_pkg::REX_BASE | 8'h01, xmsad_pkg::OP_MOV_ST,
                        8'h04, 8'h46, 8'h00, 8'h00));
        send_item(insn6(xmsad_pkg::OP_MOV_ST, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00));
        send_item(insn6(xmsad_pkg::REX_BASE | 8'h02, xmsad_pkg::OP_MOV_LD,
                        8'h04, 8'h31, 8'h00, 8'h00));

        // page table form
        set_address_mode(xmsad_pkg::MODE_PAGETABLE);
        send_item(insn6(xmsad_pkg::OP_MOV_ST, 8'h14, 8'h01, 8'h00, 8'h00, 8'h00));
        send_item(insn6(xmsad_pkg::REX_BASE | 8'h08, xmsad_pkg::OP_MOV_LD,
                        8'h04, 8'h08, 8'h00, 8'h00));
        send_item(insn6(xmsad_pkg::OP_MOV_ST, 8'h0C, 8'h01, 8'h00, 8'h00, 8'h00));
        send_item(insn6(xmsad_pkg::OP_MOV_LD, 8'h14, 8'h01, 8'h00, 8'h00, 8'h00));
        send_item(insn6(xmsad_pkg::OP_MOV_ST, 8'h14, 8'h12, 8'h00, 8'h00, 8'h00));
        send_item(insn6(xmsad_pkg::REX_BASE | 8'h01, xmsad_pkg::OP_MOV_ST,
                        8'h14, 8'h07, 8'h00, 8'h00));
        send_item(insn6(xmsad_pkg::REX_BASE | 8'h04, xmsad_pkg::OP_MOV_ST,
                        8'h14, 8'h01, 8'h00, 8'h00));

        set_address_mode(xmsad_pkg::MODE_FASTMEM);
        run_random(450);
        set_address_mode(xmsad_pkg::MODE_PAGETABLE);
        run_random(450);
        set_address_mode(xmsad_pkg::MODE_FASTMEM);
        run_random(400);

        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
